@@ hdl/spcp_pkg.sv @@
// Shared constants, codes, result type and hex decode for the serial PWM command parser.
// No dependencies; imported by every module of the block.
package spcp_pkg;

    // Argument store depth, position width and derived index width
    localparam int MAX_ARGS = 4;
    localparam int POS_W    = 5;
    localparam int IDX_W    = $clog2(MAX_ARGS);

    // Character codes
    localparam logic [7:0] CH_PWM     = 8'h70;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] PIN_OFFSET = 8'd48;
    localparam logic [POS_W-1:0] PWM_ARGC = POS_W'(3);

    // Pending error of the current line
    typedef enum logic [1:0] {
        ERR_GENERIC = 2'd0,
        ERR_ARGC    = 2'd1,
        ERR_CMD     = 2'd2
    } err_t;

    // Status reported with each result
    typedef enum logic [1:0] {
        ST_PWM_SET = 2'd0,
        ST_ARGC    = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_GENERIC = 2'd3
    } status_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] pin;
        logic [7:0] duty;
    } result_t;

    // Decode one hex digit character; anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39)
                d = c - 8'h30;
            else if (c >= 8'h41 && c <= 8'h46)
                d = c - 8'h41 + 8'd10;
            else if (c >= 8'h61 && c <= 8'h66)
                d = c - 8'h61 + 8'd10;
            return d[3:0];
        end
    endfunction

endpackage

@@ hdl/spcp_in_stage.sv @@
// Input register of the serial PWM command parser: captures one character transaction.
// Depends on spcp_pkg (none of its items needed beyond the import convention).
module spcp_in_stage
    import spcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_char,
    input  logic       advance,
    output logic       held_valid,
    output logic [7:0] held_char
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] char_reg;
    logic       load;

    // Stall while a held character cannot move on
    assign rx_stall = valid_reg && !advance;
    assign load     = rx_valid && !rx_stall;

    // Refill when the held character leaves or the register is empty
    always_comb
    begin
        valid_next = valid_reg;
        if (!rx_stall)
        begin
            valid_next = rx_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold payload until the next accepted transaction
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= rx_char;
        end
    end

    assign held_valid = valid_reg;
    assign held_char  = char_reg;

endmodule

@@ hdl/spcp_parser.sv @@
// Line state, argument store and result decode of the serial PWM command parser.
// Depends on spcp_pkg for character codes, error codes and the result type.
module spcp_parser
    import spcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] ch,
    output logic       emit,
    output result_t    result
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             is_pwm_reg;
    logic             is_pwm_next;
    err_t             err_reg;
    err_t             err_next;
    logic [7:0]       args_reg [MAX_ARGS];
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [POS_W-1:0] eff_pos;

    assign emit = (ch == CH_CR);

    // Next line state for one character
    always_comb
    begin
        pos_next    = pos_reg;
        is_pwm_next = is_pwm_reg;
        err_next    = err_reg;
        wr_en       = 1'b0;
        eff_pos     = pos_reg;
        wr_idx      = IDX_W'(pos_reg - POS_W'(1));
        if (ch == CH_CR)
        begin
            pos_next    = '0;
            is_pwm_next = 1'b0;
            err_next    = ERR_GENERIC;
        end
        else if (ch != CH_LF)
        begin
            if (pos_reg == '0 && ch == CH_PWM)
            begin
                pos_next    = POS_W'(1);
                is_pwm_next = 1'b1;
            end
            else
            begin
                // Unknown command: the character itself becomes the first argument
                if (pos_reg == '0)
                begin
                    eff_pos     = POS_W'(1);
                    is_pwm_next = 1'b0;
                    err_next    = ERR_CMD;
                end
                // Overflow: saturate and overwrite the last entry
                if (eff_pos >= POS_W'(MAX_ARGS))
                begin
                    is_pwm_next = 1'b0;
                    err_next    = ERR_ARGC;
                    pos_next    = eff_pos;
                end
                else
                begin
                    pos_next = eff_pos + POS_W'(1);
                end
                wr_en  = 1'b1;
                wr_idx = IDX_W'(eff_pos - POS_W'(1));
            end
        end
    end

    // Decode the result of the finished line
    always_comb
    begin
        result.pin    = 8'd0;
        result.duty   = 8'd0;
        result.status = ST_GENERIC;
        if (is_pwm_reg && pos_reg == PWM_ARGC + POS_W'(1))
        begin
            result.status = ST_PWM_SET;
            result.pin    = args_reg[0] - PIN_OFFSET;
            result.duty   = {hex_nibble(args_reg[1]), hex_nibble(args_reg[2])};
        end
        else if (is_pwm_reg)
        begin
            result.status = ST_ARGC;
        end
        else
        begin
            unique case (err_reg)
                ERR_GENERIC: result.status = ST_GENERIC;
                ERR_ARGC:    result.status = ST_ARGC;
                ERR_CMD:     result.status = ST_UNKNOWN;
                default:     result.status = ST_GENERIC;
            endcase
        end
    end

    // Advance line state once per processed character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            is_pwm_reg <= 1'b0;
            err_reg    <= ERR_GENERIC;
        end
        else if (step)
        begin
            pos_reg    <= pos_next;
            is_pwm_reg <= is_pwm_next;
            err_reg    <= err_next;
        end
    end

    // Store arguments; contents survive the end of a line
    always_ff @(posedge clk)
    begin
        if (step && wr_en)
        begin
            args_reg[wr_idx] <= ch;
        end
    end

endmodule

@@ hdl/spcp_out_stage.sv @@
// Result register of the serial PWM command parser, parting the parser from the consumer.
// Depends on spcp_pkg for the result type.
module spcp_out_stage
    import spcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  result_t    load_data,
    output logic       free,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [1:0] status,
    output logic [7:0] pwm_pin,
    output logic [7:0] pwm_duty
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Free when empty or the held result is taken this cycle
    assign free = !valid_reg || !res_stall;

    always_comb
    begin
        valid_next = valid_reg && res_stall;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign res_valid = valid_reg;
    assign status    = data_reg.status;
    assign pwm_pin   = data_reg.pin;
    assign pwm_duty  = data_reg.duty;

endmodule

@@ hdl/serial_pwm_command_parser_top.sv @@
// Top level of the serial PWM command parser: input register, parser, result register.
// Depends on spcp_pkg, spcp_in_stage, spcp_parser and spcp_out_stage.
//
//   channel   direction  handshake            payload
//   rx        in         rx_valid / rx_stall   rx_char[7:0]
//   res       out        res_valid / res_stall status[1:0], pwm_pin[7:0], pwm_duty[7:0]
//
// One character per cycle while neither register stalls. A character waits in the input register, where
// the parser updates its line state as it moves on; a carriage return loads the result
// register as it leaves the input register, so its result is valid once it has passed through both.
// Reset clears the line state and both valid flags; the argument store is not reset.
// A stalled result holds the next carriage return in the input register; characters
// ahead of it keep flowing.
module serial_pwm_command_parser_top
    import spcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_char,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [1:0] status,
    output logic [7:0] pwm_pin,
    output logic [7:0] pwm_duty
);

    logic       held_valid;
    logic [7:0] held_char;
    logic       emit;
    logic       out_free;
    logic       advance;
    result_t    result;

    // Move a held character on unless its result has nowhere to go
    assign advance = held_valid && (!emit || out_free);

    spcp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_char    (rx_char),
        .advance    (advance),
        .held_valid (held_valid),
        .held_char  (held_char)
    );

    spcp_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ch     (held_char),
        .emit   (emit),
        .result (result)
    );

    spcp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && emit),
        .load_data (result),
        .free      (out_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .status    (status),
        .pwm_pin   (pwm_pin),
        .pwm_duty  (pwm_duty)
    );

endmodule
